@@ rtl/core/mesh_bounds_box_sphere_unit_macros.svh @@
// Assertion macros for the mesh bounds unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef MESH_BOUNDS_BOX_SPHERE_UNIT_MACROS_SVH
`define MESH_BOUNDS_BOX_SPHERE_UNIT_MACROS_SVH
`define MBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/mbs_pkg.sv @@
// Package for the mesh bounds unit: defaults, state encoding.
// No dependencies.
package mbs_pkg;
    localparam int MaxVertices = 4096;
    localparam int CoordBits   = 24;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SCAN,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage

@@ rtl/core/mesh_bounds_box_sphere_unit.sv @@
// Mesh bounds unit: centroid, half extents and bounding-sphere radius.
// Depends on mbs_pkg, mbs_store, mbs_div, mbs_sqrt and the macros header.
// Vertices load one per cycle into the store while sums and min/max update; a vertex past
// MAX_VERTICES is dropped and sets the overflow bit of the result. After the last vertex
// the input is held off through serial division of the SW-bit sums (SW = COORD_BITS plus
// the count width), a scan of the store (one read per cycle, distance pipeline of three
// registers), a serial square root and the move of the result into the output register.
// The next mesh loads while the result word waits there; if it still waits when the next
// result is ready, the unit holds.
`include "mesh_bounds_box_sphere_unit_macros.svh"
module mesh_bounds_box_sphere_unit #(
    parameter int MAX_VERTICES = mbs_pkg::MaxVertices,
    parameter int COORD_BITS   = mbs_pkg::CoordBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
    input  logic         s_axis_tlast,   // last_vertex
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata    // center_x/y/z, half_extent_x/y/z, radius, overflowed
);
    localparam int CB   = COORD_BITS;
    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NCW  = $clog2(MAX_VERTICES + 1);
    localparam int SW   = CB + NCW;
    localparam int DQW  = 2 * (CB + 1) + 2;
    localparam int RTW  = DQW / 2 + 1;

    mbs_pkg::t_state r_st, n_st;
    logic [NCW-1:0]  r_cnt;
    logic signed [SW-1:0] r_sum [3];
    logic signed [CB-1:0] r_min [3], r_max [3], w_p [3], r_c [3];
    logic            r_ovf;
    logic [AW-1:0]   r_ra;
    logic [NCW-1:0]  r_scan;
    logic [1:0]      r_axis;
    logic            r_v1, r_v2, r_v3;
    logic [3*CB-1:0] w_rd;
    logic [2*CB+1:0] r_sq [3];
    logic [DQW-1:0]  r_d2, r_maxd;
    logic            w_acc, w_take;
    mbs_pkg::t_div_ctl w_div;
    logic            r_dbusy;
    logic            w_div_done, w_sq_done;
    logic            w_sq_start;
    logic signed [SW-1:0] w_quo;
    logic [RTW-1:0]  w_root;
    logic [167:0]    r_out;
    logic            r_ovalid;
    logic            w_load_out;
    logic signed [SW-1:0] w_num;
    logic signed [CB:0] w_d [3];
    logic signed [2*CB+1:0] w_dl [3];
    logic [CB:0]     w_ext [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_p[a] = s_axis_tdata[a*24 +: CB];
        end
    end

    assign s_axis_tready = (r_st == mbs_pkg::ST_LOAD);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_take = w_acc && (r_cnt < NCW'(MAX_VERTICES));

    mbs_store #(.DEPTH(2**AW), .DW(3*CB)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_take),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({w_p[2], w_p[1], w_p[0]}),
        .i_raddr (r_ra),
        .o_rdata (w_rd)
    );

    assign w_div = {(r_st == mbs_pkg::ST_DIV) && (r_axis != 2'd3) && !r_dbusy, r_dbusy};
    assign w_num = (r_axis == 2'd0) ? r_sum[0] : (r_axis == 2'd1) ? r_sum[1] : r_sum[2];

    mbs_div #(.NW(SW), .DW(NCW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div.start),
        .i_num   (w_num),
        .i_den   (r_cnt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_sq_start = (r_st == mbs_pkg::ST_SCAN) && (r_scan == r_cnt) && !r_v1 && !r_v2
                        && !r_v3 && r_axis == 2'd0;

    mbs_sqrt #(.W(DQW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_maxd),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_load_out = (r_st == mbs_pkg::ST_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a] = $signed({w_rd[a*CB+CB-1], w_rd[a*CB +: CB]})
                   - $signed({r_c[a][CB-1], r_c[a]});
            w_dl[a] = (2*CB+2)'(w_d[a]);
            w_ext[a] = {r_max[a][CB-1], r_max[a]} - {r_min[a][CB-1], r_min[a]};
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mbs_pkg::ST_LOAD: if (w_acc && s_axis_tlast) n_st = mbs_pkg::ST_DIV;
            mbs_pkg::ST_DIV:  if (r_axis == 2'd3) n_st = mbs_pkg::ST_SCAN;
            mbs_pkg::ST_SCAN: if (w_sq_start) n_st = mbs_pkg::ST_SQRT;
            mbs_pkg::ST_SQRT: if (w_sq_done) n_st = mbs_pkg::ST_OUT;
            mbs_pkg::ST_OUT:  if (w_load_out) n_st = mbs_pkg::ST_LOAD;
            default:          n_st = mbs_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= mbs_pkg::ST_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_axis   <= '0;
            r_dbusy  <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_scan   <= '0;
            r_maxd   <= '0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < 3; a++) r_sum[a] <= '0;
        end else begin
            r_st <= n_st;
            if (w_take) begin
                r_cnt <= r_cnt + 1'b1;
                for (int a = 0; a < 3; a++) begin
                    r_sum[a] <= r_sum[a] + SW'(w_p[a]);
                    if (r_cnt == '0 || w_p[a] < r_min[a]) r_min[a] <= w_p[a];
                    if (r_cnt == '0 || w_p[a] > r_max[a]) r_max[a] <= w_p[a];
                end
            end else if (w_acc) begin
                r_ovf <= 1'b1;
            end
            if (r_st == mbs_pkg::ST_LOAD && w_acc && s_axis_tlast) begin
                r_axis <= '0;
                r_scan <= '0;
                r_maxd <= '0;
                r_ra   <= '0;
            end
            if (w_div.start) r_dbusy <= 1'b1;
            if (w_div_done) begin
                r_dbusy <= 1'b0;
                r_c[r_axis] <= CB'(w_quo);
                r_axis <= r_axis + 1'b1;
            end
            if (r_st == mbs_pkg::ST_DIV && r_axis == 2'd3) r_axis <= '0;
            r_v1 <= (r_st == mbs_pkg::ST_SCAN) && (r_scan != r_cnt);
            if ((r_st == mbs_pkg::ST_SCAN) && (r_scan != r_cnt)) begin
                r_scan <= r_scan + 1'b1;
                r_ra   <= r_ra + 1'b1;
            end
            r_v2 <= r_v1;
            if (r_v1) begin
                for (int a = 0; a < 3; a++) r_sq[a] <= $unsigned(w_dl[a] * w_dl[a]);
            end
            r_v3 <= r_v2;
            if (r_v2) r_d2 <= DQW'(r_sq[0]) + DQW'(r_sq[1]) + DQW'(r_sq[2]);
            if (r_v3 && r_d2 > r_maxd) r_maxd <= r_d2;
            if (w_load_out) begin
                for (int a = 0; a < 3; a++) begin
                    r_out[a*24 +: 24] <= 24'(r_c[a]);
                    r_out[72 + a*23 +: 23] <= 23'(w_ext[a] >> 1);
                end
                r_out[141 +: 25] <= 25'(w_root);
                r_out[166]       <= r_ovf;
                r_out[167]       <= 1'b0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
                for (int a = 0; a < 3; a++) r_sum[a] <= '0;
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    `MBS_ASSERT_IMPL(a_no_in_busy, r_st != mbs_pkg::ST_LOAD, !s_axis_tready, "ready while busy")
    `MBS_ASSERT_IMPL(a_cnt_cap, 1'b1, r_cnt <= NCW'(MAX_VERTICES), "count past capacity")
    `MBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(r_out), "word not held")
endmodule

@@ rtl/core/mbs_div.sv @@
// Serial signed divider (truncating toward zero), one quotient bit a cycle.
// No dependencies.
module mbs_div #(
    parameter int NW = 36,
    parameter int DW = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic        [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quo
);
    localparam int CNTW = $clog2(NW + 1);
    logic [NW-1:0]   r_q, n_q;
    logic [DW:0]     r_rem, n_rem;
    logic [DW-1:0]   r_den;
    logic            r_neg;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_sh;

    always_comb begin
        w_sh    = {r_rem[DW-1:0], r_q[NW-1]};
        w_trial = w_sh - {1'b0, r_den};
        n_q     = {r_q[NW-2:0], ~w_trial[DW]};
        n_rem   = w_trial[DW] ? w_sh : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
                r_neg  <= i_num[NW-1];
                r_q    <= i_num[NW-1] ? -i_num : i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

@@ rtl/core/mbs_sqrt.sv @@
// Serial integer square root, one result bit a cycle.
// No dependencies.
module mbs_sqrt #(
    parameter int W = 52
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_val,
    output logic             o_done,
    output logic [W/2:0]     o_root
);
    localparam int RWD  = W / 2 + 1;
    localparam int STPS = RWD;
    localparam int CNTW = $clog2(STPS + 1);
    logic [2*RWD-1:0] r_val;
    logic [RWD+1:0]   r_rem;
    logic [RWD-1:0]   r_root;
    logic [CNTW-1:0]  r_cnt;
    logic             r_busy;
    logic [RWD+1:0]   w_sh, w_try;

    always_comb begin
        w_sh  = {r_rem[RWD-1:0], r_val[2*RWD-1 -: 2]};
        w_try = w_sh - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_val  <= (2*RWD)'(i_val);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(STPS);
            end else if (r_busy) begin
                r_val <= {r_val[2*RWD-3:0], 2'b00};
                if (!w_try[RWD+1]) begin
                    r_rem  <= w_try;
                    r_root <= {r_root[RWD-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_root <= {r_root[RWD-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
endmodule

@@ rtl/core/mbs_store.sv @@
// Vertex store: one write port, one registered read port.
// Depends on mbs_pkg.
module mbs_store #(
    parameter int DEPTH = mbs_pkg::MaxVertices,
    parameter int DW    = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
